// ===== hw/rtl/ird_pkg.sv =====
// Shared types, constants and helper functions of the IR proximity detector.
package ird_pkg;

  // Sample and field widths.
  localparam int SAMPLE_BITS   = 12;
  localparam int CH_BITS       = 4;
  localparam int THR_BITS      = 12;
  localparam int DIFF_OUT_BITS = 12;
  localparam int CNT_BITS      = 4;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;
  localparam int CMP_BITS      = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

  // Channel map: cliff channels first, then the wall channels.
  localparam int NUM_CH     = 9;
  localparam int NUM_CLIFF  = 4;
  localparam logic [CH_BITS-1:0] CH_WALL_LEFT  = CH_BITS'(4);
  localparam logic [CH_BITS-1:0] CH_WALL_RIGHT = CH_BITS'(8);

  // Crosstalk is the reference difference divided by 30, done as a reciprocal multiply.
  // The rounded-up reciprocal with a 21-bit shift is exact for values below 2^16.
  localparam int XTALK_DIV    = 30;
  localparam int XT_SHIFT     = 21;
  localparam int XT_MULT_BITS = 17;
  localparam int XT_MULT      = ((1 << XT_SHIFT) + XTALK_DIV - 1) / XTALK_DIV;
  localparam int PROD_BITS    = SAMPLE_BITS + XT_MULT_BITS;

  // Debounce limits: a flag changes once its counter exceeds the limit.
  localparam logic [CNT_BITS-1:0] DET_ON_AFTER    = CNT_BITS'(9);
  localparam logic [CNT_BITS-1:0] DET_OFF_AFTER   = CNT_BITS'(4);
  localparam logic [CNT_BITS-1:0] CLOSE_ON_AFTER  = CNT_BITS'(5);
  localparam logic [CNT_BITS-1:0] CLOSE_OFF_AFTER = CNT_BITS'(9);
  localparam logic [CNT_BITS-1:0] CNT_HOLD        = CNT_BITS'(10);

  // Reset values of the threshold registers.
  localparam logic [THR_BITS-1:0] CLIFF_THR_RST       = THR_BITS'(30);
  localparam logic [THR_BITS-1:0] WALL_OUTER_THR_RST  = THR_BITS'(150);
  localparam logic [THR_BITS-1:0] WALL_INNER_THR_RST  = THR_BITS'(120);
  localparam logic [THR_BITS-1:0] CLOSE_THR_RST       = THR_BITS'(50);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CLIFF_EN        = 3'd0,
    REG_WALL_EN         = 3'd1,
    REG_CLIFF_THR       = 3'd2,
    REG_WALL_OUTER_THR  = 3'd3,
    REG_WALL_INNER_THR  = 3'd4,
    REG_CLOSE_THR       = 3'd5
  } cfg_reg_t;

  // One input request.
  typedef struct packed {
    logic [CH_BITS-1:0]     channel;
    logic [SAMPLE_BITS-1:0] dark_sample;
    logic [SAMPLE_BITS-1:0] lit_sample;
    logic [CH_BITS-1:0]     reference_channel;
    logic                   use_reference;
  } in_item_t;

  // One result request.
  typedef struct packed {
    logic [CH_BITS-1:0]       result_channel;
    logic [DIFF_OUT_BITS-1:0] signal_difference;
    logic                     detected;
    logic                     close_detected;
  } out_item_t;

  // Configuration register contents.
  typedef struct packed {
    logic                cliff_en;
    logic                wall_en;
    logic [THR_BITS-1:0] cliff_thr;
    logic [THR_BITS-1:0] wall_outer_thr;
    logic [THR_BITS-1:0] wall_inner_thr;
    logic [THR_BITS-1:0] close_thr;
  } cfg_t;

  // Write of a new stored difference into the difference memory.
  typedef struct packed {
    logic                   en;
    logic [CH_BITS-1:0]     addr;
    logic [SAMPLE_BITS-1:0] data;
  } sd_wr_t;

  // Source of the two registered difference reads.
  typedef struct packed {
    logic ref_fwd;
    logic ref_ok;
    logic own_fwd;
    logic own_ok;
  } rd_sel_t;

  // One debouncer's state.
  typedef struct packed {
    logic [CNT_BITS-1:0] up;
    logic [CNT_BITS-1:0] down;
    logic                flag;
  } deb_t;

  // Advance a debouncer by one level comparison.
  function automatic deb_t deb_step(deb_t cur, logic above,
                                    logic [CNT_BITS-1:0] on_after,
                                    logic [CNT_BITS-1:0] off_after);
    deb_t nxt;
    nxt = cur;
    if (above) begin
      nxt.up   = cur.up + CNT_BITS'(1);
      nxt.down = '0;
      if (nxt.up > on_after) begin
        nxt.flag = 1'b1;
        nxt.up   = CNT_HOLD;
      end
    end else begin
      nxt.up   = '0;
      nxt.down = cur.down + CNT_BITS'(1);
      if (nxt.down > off_after) begin
        nxt.flag = 1'b0;
        nxt.down = CNT_HOLD;
      end
    end
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/ir_proximity_debounce_detector_top.sv =====
// Top level of the ambient-compensated IR proximity detector with debounce.
//
//   port group | direction | payload type        | handshake
//   in_        | input     | ird_pkg::in_item_t  | in_valid / in_stall
//   out_       | output    | ird_pkg::out_item_t | out_valid / out_stall
//   cfg_       | input     | 12-bit write data   | cfg_wr_en, no wait
//
// A request is registered at acceptance together with the two reads of the
// difference memory; the result is computed from it and is written to the
// output register when free; one request per cycle is taken while not stalled.
// The memory read at acceptance is bypassed by the write of the request ahead.
// Reset is synchronous; no memory clearing pass is needed, since per-entry
// valid bits make unwritten differences read as zero.
// While the output register holds an untaken result, one more request can wait
// in the input register before in_stall rises.
module ir_proximity_debounce_detector_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ird_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ird_pkg::out_item_t                out_data,
  input  logic                              cfg_wr_en,
  input  logic [ird_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ird_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);
  import ird_pkg::*;

  cfg_t      cfg_r;
  cfg_t      cfg_nxt;
  logic      s0_vld_r;
  logic      s0_vld_nxt;
  in_item_t  s0_item_r;
  logic      out_vld_r;
  logic      out_vld_nxt;
  out_item_t out_data_r;

  logic [NUM_CH-1:0]      sd_vld_r;
  logic [NUM_CH-1:0]      sd_vld_nxt;
  rd_sel_t                rd_sel_r;
  rd_sel_t                rd_sel_nxt;
  logic [SAMPLE_BITS-1:0] fwd_data_r;
  logic [SAMPLE_BITS-1:0] ram_q_ref;
  logic [SAMPLE_BITS-1:0] ram_q_own;
  logic [SAMPLE_BITS-1:0] ref_diff;
  logic [SAMPLE_BITS-1:0] own_diff;

  logic      adv;
  logic      accept;
  logic      fire;
  sd_wr_t    core_wr;
  out_item_t core_res;

  // Handshake: the input register moves on whenever the output register is free.
  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = s0_vld_r && !adv;
  assign accept   = in_valid && !in_stall;
  assign fire     = s0_vld_r && adv;

  // Configuration register writes.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CLIFF_EN:       cfg_nxt.cliff_en       = cfg_wdata[0];
        REG_WALL_EN:        cfg_nxt.wall_en        = cfg_wdata[0];
        REG_CLIFF_THR:      cfg_nxt.cliff_thr      = THR_BITS'(cfg_wdata);
        REG_WALL_OUTER_THR: cfg_nxt.wall_outer_thr = THR_BITS'(cfg_wdata);
        REG_WALL_INNER_THR: cfg_nxt.wall_inner_thr = THR_BITS'(cfg_wdata);
        REG_CLOSE_THR:      cfg_nxt.close_thr      = THR_BITS'(cfg_wdata);
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  // Read sources: out-of-range or unwritten entries read as zero, and a
  // write by the request ahead is forwarded.
  always_comb begin
    rd_sel_nxt.ref_fwd = core_wr.en && (core_wr.addr == in_data.reference_channel);
    rd_sel_nxt.ref_ok  = (int'(in_data.reference_channel) < NUM_CH) ?
                         sd_vld_r[in_data.reference_channel] : 1'b0;
    rd_sel_nxt.own_fwd = core_wr.en && (core_wr.addr == in_data.channel);
    rd_sel_nxt.own_ok  = (int'(in_data.channel) < NUM_CH) ?
                         sd_vld_r[in_data.channel] : 1'b0;
  end

  // Valid bits of the difference memory.
  always_comb begin
    sd_vld_nxt = sd_vld_r;
    if (core_wr.en) begin
      sd_vld_nxt[core_wr.addr] = 1'b1;
    end
  end

  // Next state of the two stage valids.
  always_comb begin
    if (accept) begin
      s0_vld_nxt = 1'b1;
    end else if (adv) begin
      s0_vld_nxt = 1'b0;
    end else begin
      s0_vld_nxt = s0_vld_r;
    end
    if (fire) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r     <= '{cliff_en: 1'b0, wall_en: 1'b0, cliff_thr: CLIFF_THR_RST,
                     wall_outer_thr: WALL_OUTER_THR_RST,
                     wall_inner_thr: WALL_INNER_THR_RST, close_thr: CLOSE_THR_RST};
      s0_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      sd_vld_r  <= '0;
    end else begin
      cfg_r     <= cfg_nxt;
      s0_vld_r  <= s0_vld_nxt;
      out_vld_r <= out_vld_nxt;
      sd_vld_r  <= sd_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s0_item_r  <= in_data;
      rd_sel_r   <= rd_sel_nxt;
      fwd_data_r <= core_wr.data;
    end
    if (fire) begin
      out_data_r <= core_res;
    end
  end

  // Stored differences of all channels.
  ird_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (NUM_CH)
  ) u_sd_ram (
    .clk       (clk),
    .wr_en     (core_wr.en),
    .wr_addr   (core_wr.addr),
    .wr_data   (core_wr.data),
    .rd_en     (accept),
    .rd_addr_a (in_data.reference_channel),
    .rd_addr_b (in_data.channel),
    .rd_data_a (ram_q_ref),
    .rd_data_b (ram_q_own)
  );

  assign ref_diff = rd_sel_r.ref_fwd ? fwd_data_r : (rd_sel_r.ref_ok ? ram_q_ref : '0);
  assign own_diff = rd_sel_r.own_fwd ? fwd_data_r : (rd_sel_r.own_ok ? ram_q_own : '0);

  // Difference and debounce logic.
  ird_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (s0_item_r),
    .cfg      (cfg_r),
    .ref_diff (ref_diff),
    .own_diff (own_diff),
    .wr       (core_wr),
    .res      (core_res)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/ird_ram.sv =====
// Generic RAM with one write port and two registered read ports.
module ird_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 9
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_a,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port; addresses past the depth are dropped.
  always_ff @(posedge clk) begin
    if (wr_en && (int'(wr_addr) < DEPTH)) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered reads; addresses past the depth read as zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= (int'(rd_addr_a) < DEPTH) ? mem[rd_addr_a] : '0;
      rd_data_b <= (int'(rd_addr_b) < DEPTH) ? mem[rd_addr_b] : '0;
    end
  end

endmodule

// ===== hw/rtl/ird_core.sv =====
// Difference computation and per-channel debounce state of the detector.
module ird_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  ird_pkg::in_item_t               item,
  input  ird_pkg::cfg_t                   cfg,
  input  logic [ird_pkg::SAMPLE_BITS-1:0] ref_diff,
  input  logic [ird_pkg::SAMPLE_BITS-1:0] own_diff,
  output ird_pkg::sd_wr_t                 wr,
  output ird_pkg::out_item_t              res
);
  import ird_pkg::*;

  deb_t det_r   [NUM_CH];
  deb_t close_r [NUM_CH];
  deb_t det_nxt;
  deb_t close_nxt;
  deb_t det_cur;
  deb_t close_cur;

  logic                   ch_ok;
  logic                   is_wall;
  logic                   grp_en;
  logic [CH_BITS-1:0]     idx;
  logic [PROD_BITS-1:0]   prod;
  logic [SAMPLE_BITS-1:0] xt;
  logic [SAMPLE_BITS:0]   sub;
  logic [SAMPLE_BITS-1:0] diff;
  logic [THR_BITS-1:0]    thr;
  logic                   det_above;
  logic                   close_above;

  // Channel class and group enable.
  assign ch_ok   = int'(item.channel) < NUM_CH;
  assign is_wall = int'(item.channel) >= NUM_CLIFF;
  assign grp_en  = is_wall ? cfg.wall_en : cfg.cliff_en;
  assign idx     = ch_ok ? item.channel : '0;

  // Crosstalk: reference difference divided by 30 through the reciprocal multiply.
  assign prod = PROD_BITS'(ref_diff) * PROD_BITS'(XT_MULT);
  assign xt   = item.use_reference ? SAMPLE_BITS'(prod[PROD_BITS-1:XT_SHIFT]) : '0;

  // Emitter-off minus emitter-on minus crosstalk, clipped at zero.
  assign sub  = {1'b0, item.lit_sample} + {1'b0, xt};
  assign diff = ({1'b0, item.dark_sample} > sub) ?
                SAMPLE_BITS'({1'b0, item.dark_sample} - sub) : '0;

  // Detection threshold by channel class.
  always_comb begin
    if (!is_wall) begin
      thr = cfg.cliff_thr;
    end else if ((item.channel == CH_WALL_LEFT) || (item.channel == CH_WALL_RIGHT)) begin
      thr = cfg.wall_outer_thr;
    end else begin
      thr = cfg.wall_inner_thr;
    end
  end

  assign det_above   = CMP_BITS'(diff) > CMP_BITS'(thr);
  assign close_above = CMP_BITS'(diff) > CMP_BITS'(cfg.close_thr);

  // Next debounce state of the item's channel.
  assign det_cur   = det_r[idx];
  assign close_cur = close_r[idx];

  always_comb begin
    det_nxt   = det_cur;
    close_nxt = close_cur;
    if (!grp_en) begin
      det_nxt.flag = !is_wall;
      if (is_wall) begin
        close_nxt.flag = 1'b0;
      end
    end else begin
      det_nxt = deb_step(det_cur, det_above, DET_ON_AFTER, DET_OFF_AFTER);
      if (is_wall) begin
        close_nxt = deb_step(close_cur, close_above, CLOSE_ON_AFTER, CLOSE_OFF_AFTER);
      end
    end
  end

  // Per-channel state; cliff channels come out of reset detected.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        det_r[i]   <= '{up: '0, down: '0, flag: (i < NUM_CLIFF)};
        close_r[i] <= '0;
      end
    end else if (fire && ch_ok) begin
      det_r[idx]   <= det_nxt;
      close_r[idx] <= close_nxt;
    end
  end

  // New stored difference, written only for an enabled group.
  assign wr.en   = fire && ch_ok && grp_en;
  assign wr.addr = item.channel;
  assign wr.data = diff;

  // Result of this item.
  always_comb begin
    res.result_channel = item.channel;
    if (!ch_ok) begin
      res.signal_difference = '0;
      res.detected          = 1'b0;
      res.close_detected    = 1'b0;
    end else begin
      res.signal_difference = grp_en ? DIFF_OUT_BITS'(diff) : DIFF_OUT_BITS'(own_diff);
      res.detected          = det_nxt.flag;
      res.close_detected    = is_wall && close_nxt.flag;
    end
  end

endmodule

// ===== hw/rtl/ird_checker.sv =====
// Port-level assertions of the detector, bound to the top level.
module ird_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input ird_pkg::out_item_t out_data
);
  import ird_pkg::*;

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // With the output register empty, the input side never stalls.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // A cliff channel never reports a close obstacle.
  a_cliff_no_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (int'(out_data.result_channel) < NUM_CLIFF) |-> !out_data.close_detected)
    else $error("close flag on cliff channel");

  // An unknown channel reports an all-zero result.
  a_bad_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (int'(out_data.result_channel) >= NUM_CH) |->
      (out_data.signal_difference == '0) && !out_data.detected && !out_data.close_detected)
    else $error("nonzero result for unknown channel");

endmodule

bind ir_proximity_debounce_detector_top ird_checker u_ird_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
